### src/efd_pkg.sv
// efd_pkg: shared constants and types for the escaped frame deframer.
// Used by efd_decode and escaped_frame_deframer; depends on nothing.
package efd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hE0;
  localparam logic [7:0] ESC_BYTE  = 8'hD0;

  // Payload length plus sync, length, checksum and one more header byte.
  localparam logic [8:0] FRAME_OVERHEAD = 9'd4;
  localparam logic [8:0] LENGTH_POS     = 9'd3;
  localparam logic [8:0] MAX_COUNT      = 9'd259;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_SYNC = 2'd1,
    ERR_ESC  = 2'd2
  } err_t;

  typedef struct packed {
    logic       in_frame;
    logic       escape_armed;
    logic [8:0] count;
    logic [7:0] length;
  } dfr_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       first;
    logic       last;
    err_t       err;
  } dfr_result_t;

endpackage

### src/efd_decode.sv
// efd_decode: per-byte decision logic of the deframer, purely combinational.
// Depends on efd_pkg for the state and result types and the marker bytes.
module efd_decode (
  input  efd_pkg::dfr_state_t  state,
  input  logic [7:0]           in_byte,
  output efd_pkg::dfr_state_t  state_next,
  output efd_pkg::dfr_result_t result
);

  logic [7:0] data;
  logic [8:0] count_inc;
  logic [7:0] length_eff;
  logic       done;

  assign data       = state.escape_armed ? in_byte + 8'd1 : in_byte;
  assign count_inc  = state.count + 9'd1;
  assign length_eff = (count_inc == efd_pkg::LENGTH_POS) ? data : state.length;
  assign done       = (count_inc >= efd_pkg::LENGTH_POS) &&
                      (count_inc == {1'b0, length_eff} + efd_pkg::FRAME_OVERHEAD);

  always_comb begin
    state_next   = state;
    result.valid = 1'b0;
    result.data  = 8'd0;
    result.first = 1'b0;
    result.last  = 1'b0;
    result.err   = efd_pkg::ERR_NONE;
    priority if (!state.in_frame) begin
      if (in_byte == efd_pkg::SYNC_BYTE) begin
        state_next.in_frame     = 1'b1;
        state_next.escape_armed = 1'b0;
        state_next.count        = 9'd1;
        state_next.length       = 8'd0;
        result.valid            = 1'b1;
        result.data             = in_byte;
        result.first            = 1'b1;
      end
    end else if (in_byte == efd_pkg::SYNC_BYTE) begin
      state_next   = '0;
      result.valid = 1'b1;
      result.err   = efd_pkg::ERR_SYNC;
    end else if (in_byte == efd_pkg::ESC_BYTE) begin
      if (state.escape_armed) begin
        state_next   = '0;
        result.valid = 1'b1;
        result.err   = efd_pkg::ERR_ESC;
      end else begin
        state_next.escape_armed = 1'b1;
      end
    end else begin
      result.valid = 1'b1;
      result.data  = data;
      if (done) begin
        state_next  = '0;
        result.last = 1'b1;
      end else begin
        state_next.escape_armed = 1'b0;
        state_next.count        = count_inc;
        state_next.length       = length_eff;
      end
    end
  end

endmodule

### src/escaped_frame_deframer.sv
// escaped_frame_deframer: top level of the byte-stuffed frame deframer.
// Depends on efd_pkg and efd_decode.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, in_byte                | into block
//  out     | out_valid, out_ready, out_byte, is_first,  | out of block
//          | is_last, error_code                        |
//
// One raw byte is taken per item; the decode is a single pass of compare and
// increment logic from the frame state registers into the result register.
// An item yields zero or one result.
// Reset (rst, synchronous) returns the block to hunting for sync and empties
// the result register. A stall on the output holds the result register; the
// input is still taken in that cycle only if the waiting result leaves.
module escaped_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_first,
  output logic       is_last,
  output logic [1:0] error_code
);

  efd_pkg::dfr_state_t  state;
  efd_pkg::dfr_state_t  state_next;
  efd_pkg::dfr_result_t result;
  logic                 in_accept;

  // The decoder sees the frame state and the incoming byte and says what the
  // state becomes and which result, if any, the byte produces.
  efd_decode u_decode (
    .state      (state),
    .in_byte    (in_byte),
    .state_next (state_next),
    .result     (result)
  );

  // A new byte is welcome whenever the result register is empty or is being
  // drained in this same cycle, so a byte can follow in every cycle unless the output stalls.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // A new result refills the register; otherwise a drained result empties it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload carries no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_accept && result.valid) begin
      out_byte   <= result.data;
      is_first   <= result.first;
      is_last    <= result.last;
      error_code <= 2'(result.err);
    end
  end

  // An aborted frame reports nothing but the error code.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != 2'(efd_pkg::ERR_NONE))
      |-> (out_byte == 8'd0) && !is_first && !is_last)
    else $error("error result carries frame data");

  // The first byte of a frame is always the sync byte.
  a_first_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_first |-> (out_byte == efd_pkg::SYNC_BYTE) && !is_last)
    else $error("first byte is not sync");

  // While hunting, the frame counters rest at zero.
  a_hunt_idle: assert property (@(posedge clk) disable iff (rst)
    !state.in_frame |-> (state.count == 9'd0) && !state.escape_armed)
    else $error("hunting with live frame state");

  // The decoded count never passes the longest possible frame.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state.count < efd_pkg::MAX_COUNT)
    else $error("decoded count overran the frame");

  // A sync byte inside a frame always sends the block back to hunting.
  a_sync_abort: assert property (@(posedge clk) disable iff (rst)
    in_accept && state.in_frame && (in_byte == efd_pkg::SYNC_BYTE)
      |=> !state.in_frame && out_valid
          && (error_code == 2'(efd_pkg::ERR_SYNC)))
    else $error("sync inside frame did not abort");

endmodule

### dv/deframe_checker.sv
// deframe_checker: watches both channels of the escaped frame deframer, predicts
// each decoded byte and compares it with what leaves the block.
// Depends on efd_pkg for the sync and escape codes, error codes and state type.
`timescale 1ns / 100ps

module deframe_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       is_first,
  input  logic       is_last,
  input  logic [1:0] error_code,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0]    data;
    logic          first;
    logic          last;
    efd_pkg::err_t err;
  } frame_out_t;

  localparam int REPORT_LIMIT = 10;

  efd_pkg::dfr_state_t frame_st;
  frame_out_t          frame_bytes_due[$];
  int                  mismatches = 0;

  assign fail_count = mismatches;

  // Decodes one raw byte against the frame state; returns 1 when it yields a result.
  function automatic bit predict_frame_byte(input logic [7:0] b, output frame_out_t r);
    logic [7:0] d;
    r = '{8'd0, 1'b0, 1'b0, efd_pkg::ERR_NONE};
    if (!frame_st.in_frame) begin
      if (b != efd_pkg::SYNC_BYTE) return 1'b0;
      frame_st = '0;
      frame_st.in_frame = 1'b1;
      frame_st.count = 9'd1;
      r.data = b;
      r.first = 1'b1;
      return 1'b1;
    end
    if (b == efd_pkg::SYNC_BYTE) begin
      frame_st = '0;
      r.err = efd_pkg::ERR_SYNC;
      return 1'b1;
    end
    if (b == efd_pkg::ESC_BYTE) begin
      if (frame_st.escape_armed) begin
        frame_st = '0;
        r.err = efd_pkg::ERR_ESC;
        return 1'b1;
      end
      frame_st.escape_armed = 1'b1;
      return 1'b0;
    end
    d = frame_st.escape_armed ? b + 8'd1 : b;
    frame_st.escape_armed = 1'b0;
    frame_st.count = frame_st.count + 9'd1;
    if (frame_st.count == efd_pkg::LENGTH_POS) frame_st.length = d;
    r.data = d;
    if (frame_st.count >= efd_pkg::LENGTH_POS &&
        frame_st.count == {1'b0, frame_st.length} + efd_pkg::FRAME_OVERHEAD) begin
      frame_st = '0;
      r.last = 1'b1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    frame_out_t want;
    frame_out_t got;
    if (rst) begin
      frame_st = '0;
      frame_bytes_due.delete();
    end else begin
      // A result leaving now comes from an earlier item, so match before adding.
      if (out_valid && out_ready) begin
        got = '{out_byte, is_first, is_last, efd_pkg::err_t'(error_code)};
        if (frame_bytes_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected item data=%h first=%b last=%b err=%0d", $realtime,
                     got.data, got.first, got.last, got.err);
          mismatches++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (got != want) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: mismatch exp d=%h f=%b l=%b e=%0d got d=%h f=%b l=%b e=%0d",
                       $realtime, want.data, want.first, want.last, want.err,
                       got.data, got.first, got.last, got.err);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (predict_frame_byte(in_byte, want)) frame_bytes_due.push_back(want);
      end
    end
    pending <= frame_bytes_due.size();
  end

endmodule

### dv/tb_escaped_frame_deframer.sv
// tb_escaped_frame_deframer: drives raw serial bytes into the deframer, stalls its
// output, and gives the verdict. Depends on efd_pkg, escaped_frame_deframer and
// deframe_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module tb_escaped_frame_deframer;

  localparam int ITEM_TARGET = 750;
  // No idling on either side once this many items have gone in.
  localparam int CALM_FROM   = ITEM_TARGET - 120;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_AT     = 350;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       is_first;
  logic       is_last;
  logic [1:0] error_code;

  int   fail_count;
  int   pending;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  logic calm;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;

  // Opening directed bytes. Two bytes dropped while hunting (all zeros, all ones),
  // then a frame with an escaped 0xFF payload that decodes to 0x00 and a length
  // of one, then a frame whose second byte is an escaped sync and whose length is
  // zero, then a sync inside a frame followed by a byte dropped while hunting, a
  // double escape, and a sync arriving right after an escape.
  logic [7:0] opening_bytes [23] = '{
    8'h00, 8'hFF,
    8'hE0, 8'h7F, 8'h01, 8'hD0, 8'hFF, 8'h80,
    8'hE0, 8'hD0, 8'hDF, 8'h00, 8'hFF,
    8'hE0, 8'h12, 8'hE0, 8'h05,
    8'hE0, 8'hD0, 8'hD0,
    8'hE0, 8'hD0, 8'hE0
  };

  assign calm = (items_sent >= CALM_FROM);

  escaped_frame_deframer uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .is_first   (is_first),
    .is_last    (is_last),
    .error_code (error_code)
  );

  deframe_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .is_first   (is_first),
    .is_last    (is_last),
    .error_code (error_code),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one raw byte and waits until it is taken. A random idle burst may come
  // first; valid only drops during that burst, never while a byte is on offer.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Sends one decoded byte the way a sender would stuff it. Sync and escape codes
  // must be escaped; other bytes are escaped now and then, except where the sent
  // byte would itself be a sync or escape code.
  task automatic send_decoded(input logic [7:0] d);
    logic [7:0] lowered;
    lowered = d - 8'd1;
    if (d == efd_pkg::SYNC_BYTE || d == efd_pkg::ESC_BYTE ||
        (lowered != efd_pkg::SYNC_BYTE && lowered != efd_pkg::ESC_BYTE &&
         $urandom_range(0, 7) == 0)) begin
      send_byte(efd_pkg::ESC_BYTE);
      send_byte(lowered);
    end else begin
      send_byte(d);
    end
  endtask

  // A frame is sync, a header byte, the length, the payload and a checksum byte,
  // len + 4 decoded bytes in all. With break_at in range, the frame is cut at that
  // decoded position by a sync, a double escape, or an escape followed by a sync.
  task automatic send_frame(input int len, input int break_at);
    logic [7:0] d;
    int idx;
    send_byte(efd_pkg::SYNC_BYTE);
    for (idx = 1; idx < len + 4; idx++) begin
      if (idx == break_at) begin
        case ($urandom_range(0, 2))
          0: send_byte(efd_pkg::SYNC_BYTE);
          1: begin
            send_byte(efd_pkg::ESC_BYTE);
            send_byte(efd_pkg::ESC_BYTE);
          end
          default: begin
            send_byte(efd_pkg::ESC_BYTE);
            send_byte(efd_pkg::SYNC_BYTE);
          end
        endcase
        return;
      end
      if (idx == 2) begin
        d = len[7:0];
      end else if ($urandom_range(0, 5) == 0) begin
        // Bias toward the codes and their neighbors.
        case ($urandom_range(0, 5))
          0: d = efd_pkg::SYNC_BYTE;
          1: d = efd_pkg::ESC_BYTE;
          2: d = 8'hDF;
          3: d = 8'hCF;
          4: d = 8'hFF;
          default: d = 8'h00;
        endcase
      end else begin
        d = 8'($urandom_range(0, 255));
      end
      send_decoded(d);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sender: reset, directed bytes, a full drain, the longest frame, then random frames.
  initial begin
    int pick;
    int len;
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < 23; k++) send_byte(opening_bytes[k]);

    // Pause with nothing on offer until every result so far has come out.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // The longest frame the length byte allows.
    send_frame(255, -1);

    // Mostly well-formed frames with random content; some are cut short by an
    // abort, and some stretches are plain noise while hunting.
    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        // The receiver stops for a long stretch while bytes keep coming.
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 9);
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (pick < 7) begin
        send_frame(len, -1);
      end else if (pick < 9) begin
        send_frame(len, int'($urandom_range(1, len + 3)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
src/efd_pkg.sv
src/efd_decode.sv
src/escaped_frame_deframer.sv
dv/deframe_checker.sv
dv/tb_escaped_frame_deframer.sv
